[src/sss_pkg.sv]
`timescale 1ns / 1ps

package sss_pkg;

    // build constants
    localparam int CORDIC_STEPS = 18;
    localparam int COORD_BITS   = 40;

    // angle handling, 1/256 degree units
    localparam int FULL_TURN    = 92160;
    localparam int QUARTER_TURN = 23040;
    localparam int ANG_W        = 17;
    localparam int REM_W        = 15;
    localparam int QUAD_W       = 2;

    // cordic datapath widths: Q30 vectors, degrees * 2^24 angles
    localparam int CW         = 33;
    localparam int ZW         = 33;
    localparam int MAX_STEPS  = 30;
    localparam int STEP_W     = 5;
    localparam int GAIN_Q30   = 652032874;

    // interval in millimetres and the product width
    localparam int LEN_W = 26;
    localparam int PW    = LEN_W + 1 + CW;

    // round(atan(2^-i) * 180/pi * 2^24)
    localparam logic [ZW-2:0] ATAN_DEG24 [MAX_STEPS] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
        32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
        32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
        32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115,       32'd57,
        32'd29,        32'd14,        32'd7,         32'd4,         32'd2
    };

    // input beat
    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_easting;
        logic signed [COORD_BITS-1:0] start_northing;
        logic signed [COORD_BITS-1:0] start_elevation;
        logic        [ANG_W-1:0]      bearing;
        logic signed [15:0]           dip;
        logic        [15:0]           interval_m;
    } t_sss_in;

    // output beat
    typedef struct packed {
        logic signed [COORD_BITS-1:0] next_easting;
        logic signed [COORD_BITS-1:0] next_northing;
        logic signed [COORD_BITS-1:0] next_elevation;
    } t_sss_out;

    // one rotation in flight
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_sss_rot;

    // fields carried alongside the rotations
    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_e;
        logic signed [COORD_BITS-1:0] start_n;
        logic signed [COORD_BITS-1:0] start_u;
        logic        [LEN_W-1:0]      len_mm;
        logic        [QUAD_W-1:0]     q_bear;
        logic        [QUAD_W-1:0]     q_dip;
    } t_sss_carry;

    // contents of one cell of the chain
    typedef struct packed {
        t_sss_rot   bear;
        t_sss_rot   dip;
        t_sss_carry side;
    } t_sss_cell;

    // scaled increments before rounding
    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_e;
        logic signed [COORD_BITS-1:0] start_n;
        logic signed [COORD_BITS-1:0] start_u;
        logic signed [PW-1:0]         p_e;
        logic signed [PW-1:0]         p_n;
        logic signed [PW-1:0]         p_u;
    } t_sss_prod;

endpackage

[src/sss_front.sv]
`timescale 1ns / 1ps

module sss_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  sss_pkg::t_sss_in  i_data,
    output logic              o_valid,
    output sss_pkg::t_sss_cell o_data
);
    import sss_pkg::*;

    typedef struct packed {
        logic [QUAD_W-1:0] q;
        logic [REM_W-1:0]  r;
    } t_quad;

    // split an angle below a full turn into quadrant and remainder
    function automatic t_quad split_angle(input logic [ANG_W-1:0] a);
        t_quad res;
        if (a >= ANG_W'(3 * QUARTER_TURN)) begin
            res.q = 2'd3;
            res.r = REM_W'(a - ANG_W'(3 * QUARTER_TURN));
        end else if (a >= ANG_W'(2 * QUARTER_TURN)) begin
            res.q = 2'd2;
            res.r = REM_W'(a - ANG_W'(2 * QUARTER_TURN));
        end else if (a >= ANG_W'(QUARTER_TURN)) begin
            res.q = 2'd1;
            res.r = REM_W'(a - ANG_W'(QUARTER_TURN));
        end else begin
            res.q = 2'd0;
            res.r = REM_W'(a);
        end
        return res;
    endfunction

    logic [ANG_W-1:0] bear_wrap;
    logic [ANG_W-1:0] dip_wrap;
    t_quad            bear_q;
    t_quad            dip_q;
    t_sss_cell        n_data;
    logic             r_valid;
    t_sss_cell        r_data;

    // wrap both angles into one turn
    always_comb begin
        if (i_data.bearing >= ANG_W'(FULL_TURN)) begin
            bear_wrap = i_data.bearing - ANG_W'(FULL_TURN);
        end else begin
            bear_wrap = i_data.bearing;
        end
        if (i_data.dip < 0) begin
            dip_wrap = ANG_W'(ANG_W'({1'b1, i_data.dip}) + ANG_W'(FULL_TURN));
        end else begin
            dip_wrap = ANG_W'(i_data.dip);
        end
        bear_q = split_angle(bear_wrap);
        dip_q  = split_angle(dip_wrap);
    end

    // initial vectors and side fields
    always_comb begin
        n_data.bear.x = CW'(GAIN_Q30);
        n_data.bear.y = '0;
        n_data.bear.z = ZW'({bear_q.r, 16'b0});
        n_data.dip.x  = CW'(GAIN_Q30);
        n_data.dip.y  = '0;
        n_data.dip.z  = ZW'({dip_q.r, 16'b0});
        n_data.side.start_e = i_data.start_easting;
        n_data.side.start_n = i_data.start_northing;
        n_data.side.start_u = i_data.start_elevation;
        n_data.side.len_mm  = LEN_W'(i_data.interval_m) * LEN_W'(1000);
        n_data.side.q_bear  = bear_q.q;
        n_data.side.q_dip   = dip_q.q;
    end

    // entry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // remainders stay inside one quadrant
    a_front_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data.bear.z >= 0) && (r_data.bear.z < ZW'(QUARTER_TURN * 65536))
                 && (r_data.dip.z >= 0) && (r_data.dip.z < ZW'(QUARTER_TURN * 65536)))
        else $error("angle remainder outside one quadrant");

endmodule

[src/sss_cordic_cell.sv]
`timescale 1ns / 1ps

module sss_cordic_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [sss_pkg::STEP_W-1:0] i_step,
    input  logic                 i_valid,
    input  sss_pkg::t_sss_cell   i_data,
    output logic                 o_valid,
    output sss_pkg::t_sss_cell   o_data
);
    import sss_pkg::*;

    // one micro-rotation, shifts floor toward minus infinity
    function automatic t_sss_rot rotate(input t_sss_rot a, input logic [STEP_W-1:0] s);
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [ZW-1:0] t;
        t_sss_rot             res;
        dx = a.x;
        dy = a.y;
        dx = dy >>> s;
        dy = a.x >>> s;
        t  = ZW'(ATAN_DEG24[s]);
        if (a.z >= 0) begin
            res.x = a.x - dx;
            res.y = a.y + dy;
            res.z = a.z - t;
        end else begin
            res.x = a.x + dx;
            res.y = a.y - dy;
            res.z = a.z + t;
        end
        return res;
    endfunction

    t_sss_cell n_data;
    logic      r_valid;
    t_sss_cell r_data;

    // turn both vectors, pass the side fields on
    always_comb begin
        n_data.bear = rotate(i_data.bear, i_step);
        n_data.dip  = rotate(i_data.dip, i_step);
        n_data.side = i_data.side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // a stalled cell keeps its contents
    a_cell_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en && r_valid |=> r_valid && $stable(r_data))
        else $error("cordic cell lost its beat during a stall");

    // the side fields ride along untouched
    a_cell_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_valid |=> r_valid && (r_data.side == $past(i_data.side)))
        else $error("side fields changed inside a cordic cell");

endmodule

[src/sss_back.sv]
`timescale 1ns / 1ps

module sss_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  sss_pkg::t_sss_cell i_data,
    output logic               o_valid,
    output sss_pkg::t_sss_out  o_data
);
    import sss_pkg::*;

    localparam int SW = COORD_BITS + 1;
    localparam int IW = PW - 30;
    localparam logic signed [PW-1:0] HALF   = PW'(1) << 29;
    localparam logic signed [SW-1:0] SAT_HI = {2'b00, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {2'b11, {(COORD_BITS-1){1'b0}}};

    // round the scaled product to millimetres and add with saturation
    function automatic logic signed [COORD_BITS-1:0] sat_add(
        input logic signed [COORD_BITS-1:0] start,
        input logic signed [PW-1:0]         p
    );
        logic signed [PW-1:0] rnd;
        logic signed [IW-1:0] inc;
        logic signed [SW-1:0] sum;
        rnd = p + HALF;
        inc = $signed(rnd[PW-1:30]);
        sum = SW'(start) + SW'(inc);
        if (sum > SAT_HI) begin
            return SAT_HI[COORD_BITS-1:0];
        end else if (sum < SAT_LO) begin
            return SAT_LO[COORD_BITS-1:0];
        end
        return sum[COORD_BITS-1:0];
    endfunction

    logic signed [CW-1:0] sin_b;
    logic signed [CW-1:0] cos_b;
    logic signed [CW-1:0] sin_d;
    logic signed [LEN_W:0] len_s;
    t_sss_prod            n_prod;
    logic                 r_m_valid;
    t_sss_prod            r_m;
    t_sss_out             n_out;
    logic                 r_out_valid;
    t_sss_out             r_out;

    // quadrant fold of the bearing vector
    always_comb begin
        case (i_data.side.q_bear)
            2'd0: begin
                sin_b = i_data.bear.y;
                cos_b = i_data.bear.x;
            end
            2'd1: begin
                sin_b = i_data.bear.x;
                cos_b = -i_data.bear.y;
            end
            2'd2: begin
                sin_b = -i_data.bear.y;
                cos_b = -i_data.bear.x;
            end
            default: begin
                sin_b = -i_data.bear.x;
                cos_b = i_data.bear.y;
            end
        endcase
    end

    // only the sine of the slope is needed
    always_comb begin
        case (i_data.side.q_dip)
            2'd0:    sin_d = i_data.dip.y;
            2'd1:    sin_d = i_data.dip.x;
            2'd2:    sin_d = -i_data.dip.y;
            default: sin_d = -i_data.dip.x;
        endcase
    end

    // scale by the interval
    always_comb begin
        len_s          = $signed({1'b0, i_data.side.len_mm});
        n_prod.start_e = i_data.side.start_e;
        n_prod.start_n = i_data.side.start_n;
        n_prod.start_u = i_data.side.start_u;
        n_prod.p_e     = len_s * sin_b;
        n_prod.p_n     = len_s * cos_b;
        n_prod.p_u     = len_s * sin_d;
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m <= n_prod;
        end
    end

    // round and accumulate
    always_comb begin
        n_out.next_easting   = sat_add(r_m.start_e, r_m.p_e);
        n_out.next_northing  = sat_add(r_m.start_n, r_m.p_n);
        n_out.next_elevation = sat_add(r_m.start_u, r_m.p_u);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // zero travel leaves the station where it was
    a_back_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_m_valid && (r_m.p_e == 0) |=> r_out.next_easting == $past(r_m.start_e))
        else $error("zero easting increment moved the station");

    // a positive climb never lowers the station
    a_back_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_m_valid && (r_m.p_u > 0) |=> r_out.next_elevation >= $past(r_m.start_u))
        else $error("positive elevation increment lowered the station");

endmodule

[src/survey_station_step.sv]
`timescale 1ns / 1ps

// survey station step: advances a station by one interval along a bearing and slope
//
// input channel i_in_valid / o_in_ready carries one station request per beat:
// start coordinates in millimetres, bearing and dip in 1/256 degree, interval in
// metres. output channel o_out_valid / i_out_ready carries the next station,
// rounded to the millimetre and saturated at the coordinate range.
//
// throughput is one beat per cycle while the output is not stalled. the stages
// are one angle reduction register, one cordic cell per step,
// one multiply register and one round/saturate output register.
//
// the whole chain advances together: a stalled output (o_out_valid high and
// i_out_ready low) freezes every stage and drops o_in_ready in the same cycle;
// no beat is lost or repeated. reset clears every valid bit, so the block is
// empty and ready once reset is released.
module survey_station_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sss_pkg::t_sss_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sss_pkg::t_sss_out o_out_data
);
    import sss_pkg::*;

    logic      en;
    logic      w_valid [CORDIC_STEPS+1];
    t_sss_cell w_cell  [CORDIC_STEPS+1];

    // advance whenever the output register is free or being drained
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // angle reduction and entry register
    sss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (w_valid[0]),
        .o_data  (w_cell[0])
    );

    // chain of cordic cells, one per micro-rotation
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        sss_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (STEP_W'(g)),
            .i_valid (w_valid[g]),
            .i_data  (w_cell[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_cell[g+1])
        );
    end

    // quadrant fold, scaling and saturating add
    sss_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_valid[CORDIC_STEPS]),
        .i_data  (w_cell[CORDIC_STEPS]),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

[bench/survey_station_checker.sv]
`timescale 1ns / 1ps

// watches both channels of the station step, predicts each next station and
// compares it with what comes out, oldest request first
module survey_station_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  sss_pkg::t_sss_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  sss_pkg::t_sss_out i_out_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    import sss_pkg::t_sss_in;
    import sss_pkg::t_sss_out;

    localparam int     TURN       = 92160;
    localparam int     QUARTER    = 23040;
    localparam longint GAIN       = 652032874;
    localparam int     TABLE_LEN  = 30;
    localparam int     CB         = sss_pkg::COORD_BITS;
    localparam longint COORD_HI   = (64'sd1 <<< (CB - 1)) - 1;
    localparam longint COORD_LO   = -COORD_HI - 1;

    // arctangent of 2^-i in degrees scaled by 2^24
    localparam longint ARCTAN_DEG24 [TABLE_LEN] = '{
        754974720, 445687602, 235489088, 119537938, 60000934,
        30029717,  15018523,  7509720,   3754917,   1877466,
        938734,    469367,    234684,    117342,    58671,
        29335,     14668,     7334,      3667,      1833,
        917,       458,       229,       115,       57,
        29,        14,        7,         4,         2
    };

    t_sss_out stations_due [$];

    // Q30 sine and cosine of an angle in 0..TURN-1 via rotation-mode cordic
    function automatic void unit_vector(input int angle, output longint s, output longint c);
        int     quad;
        int     steps;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        quad  = angle / QUARTER;
        steps = (sss_pkg::CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : sss_pkg::CORDIC_STEPS;
        x = GAIN;
        y = 0;
        z = longint'(angle - quad * QUARTER) * 65536;
        for (int i = 0; i < steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_DEG24[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_DEG24[i];
            end
        end
        // fold the first-quadrant result out to the full angle
        case (quad)
            0: begin
                s = y;
                c = x;
            end
            1: begin
                s = x;
                c = -y;
            end
            2: begin
                s = -y;
                c = -x;
            end
            default: begin
                s = -x;
                c = y;
            end
        endcase
    endfunction

    // length times Q30 factor, rounded to the millimetre, ties upward
    function automatic longint scaled_mm(input longint len_mm, input longint factor);
        return (len_mm * factor + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // add an increment and clamp to the coordinate range
    function automatic logic signed [CB-1:0] moved(input longint start, input longint inc);
        longint sum;
        sum = start + inc;
        if (sum > COORD_HI)
            sum = COORD_HI;
        else if (sum < COORD_LO)
            sum = COORD_LO;
        return sum[CB-1:0];
    endfunction

    function automatic t_sss_out next_station(input t_sss_in req);
        t_sss_out nxt;
        int       bear;
        int       slope;
        longint   len_mm;
        longint   sin_b;
        longint   cos_b;
        longint   sin_d;
        longint   cos_d;
        bear  = int'(req.bearing);
        slope = int'(req.dip);
        // bearing past a full turn wraps once, negative dip becomes its positive angle
        if (bear >= TURN)
            bear = bear - TURN;
        if (slope < 0)
            slope = slope + TURN;
        len_mm = longint'(req.interval_m) * 1000;
        unit_vector(bear, sin_b, cos_b);
        unit_vector(slope, sin_d, cos_d);
        nxt.next_easting   = moved(longint'(req.start_easting), scaled_mm(len_mm, sin_b));
        nxt.next_northing  = moved(longint'(req.start_northing), scaled_mm(len_mm, cos_b));
        nxt.next_elevation = moved(longint'(req.start_elevation), scaled_mm(len_mm, sin_d));
        return nxt;
    endfunction

    function automatic int field_differs(input string axis, input logic signed [CB-1:0] want,
                                         input logic signed [CB-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, axis, want, got);
            return 1;
        end
        return 0;
    endfunction

    // compare the outgoing beat first, then queue the prediction for the incoming one
    always @(posedge i_clk) begin
        t_sss_out want;
        int       bad;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
            o_checked    <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (stations_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d %0d %0d",
                             $time, i_out_data.next_easting, i_out_data.next_northing,
                             i_out_data.next_elevation);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = stations_due.pop_front();
                    bad  = field_differs("easting", want.next_easting, i_out_data.next_easting)
                         + field_differs("northing", want.next_northing,
                                         i_out_data.next_northing)
                         + field_differs("elevation", want.next_elevation,
                                         i_out_data.next_elevation);
                    if (bad != 0)
                        o_fail_count <= o_fail_count + 1;
                    o_checked <= o_checked + 1;
                end
            end
            if (i_in_valid && i_in_ready)
                stations_due.push_back(next_station(i_in_data));
            o_pending <= stations_due.size();
        end
    end

endmodule

[bench/tb_survey_station_step.sv]
`timescale 1ns / 1ps

module tb_survey_station_step;

    import sss_pkg::t_sss_in;
    import sss_pkg::t_sss_out;

    localparam int     CB         = sss_pkg::COORD_BITS;
    localparam longint COORD_HI   = (64'sd1 <<< (CB - 1)) - 1;
    localparam longint COORD_LO   = -COORD_HI - 1;
    localparam int     STALL_LIMIT = 2000;
    localparam int     PHASE_BEATS = 475;
    localparam int     DRAIN_WAIT  = 30;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    t_sss_in  in_beat;
    logic     out_valid;
    logic     out_ready;
    t_sss_out out_beat;

    logic     in_burst;
    logic     out_burst;
    int       fail_count;
    int       pending;
    int       checked;
    int       sent;
    int       directed_sent;
    int       quiet_cycles;

    survey_station_step uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat)
    );

    survey_station_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 50 MHz clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // result side: random stall before taking each beat, none in burst phases
    initial begin
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            stall = out_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // one request beat, held until accepted
    task automatic send_beat(input t_sss_in beat);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_station(input longint e, input longint n, input longint u,
                                input int bear, input int slope, input int len);
        t_sss_in beat;
        beat.start_easting   = e[CB-1:0];
        beat.start_northing  = n[CB-1:0];
        beat.start_elevation = u[CB-1:0];
        beat.bearing         = bear[16:0];
        beat.dip             = slope[15:0];
        beat.interval_m      = len[15:0];
        send_beat(beat);
    endtask

    // hold the request side until every predicted station has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic longint random_coord();
        longint raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return longint'($urandom_range(0, 2097151)) - 1048576;
            4, 5, 6:    return (raw <<< (64 - CB)) >>> (64 - CB);
            7:          return COORD_HI - longint'($urandom_range(0, 70000000));
            8:          return COORD_LO + longint'($urandom_range(0, 70000000));
            default:    return ($urandom_range(0, 1) != 0) ? COORD_HI : COORD_LO;
        endcase
    endfunction

    function automatic t_sss_in random_station();
        t_sss_in beat;
        int      pick;
        int      b;
        int      d;
        int      len;
        beat.start_easting   = CB'(random_coord());
        beat.start_northing  = CB'(random_coord());
        beat.start_elevation = CB'(random_coord());
        // bearing: mostly in range, some past a full turn, some at quadrant edges
        pick = $urandom_range(0, 9);
        if (pick == 0)
            b = $urandom_range(0, 131071);
        else if (pick == 1)
            b = $urandom_range(0, 4) * 23040 + $urandom_range(0, 4) - 2;
        else
            b = $urandom_range(0, 92159);
        if (b < 0)
            b = 0;
        // dip: mostly in range, some anywhere in 16 bits, some level or vertical
        pick = $urandom_range(0, 9);
        if (pick == 0)
            d = $urandom_range(0, 65535);
        else if (pick == 1)
            d = 0;
        else if (pick == 2)
            d = ($urandom_range(0, 1) != 0) ? 23040 : -23040;
        else
            d = int'($urandom_range(0, 46080)) - 23040;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            len = 0;
        else if (pick == 1)
            len = 65535;
        else if (pick == 2)
            len = $urandom_range(1, 100);
        else
            len = $urandom_range(0, 65535);
        beat.bearing    = b[16:0];
        beat.dip        = d[15:0];
        beat.interval_m = len[15:0];
        return beat;
    endfunction

    initial begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_beat      <= '0;
        out_ready    <= 1'b0;
        in_burst     <= 1'b0;
        out_burst    <= 1'b0;
        sent          = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: angle edges, wrap-around, steep dips, saturation, zero length
        send_station(0, 0, 0, 0, 0, 0);
        send_station(0, 0, 0, 0, 0, 65535);
        send_station(0, 0, 0, 23040, 23040, 65535);
        send_station(1234, -5678, 999, 46080, -23040, 65535);
        send_station(0, 0, 0, 69120, 32767, 65535);
        send_station(0, 0, 0, 92159, -32768, 65535);
        send_station(0, 0, 0, 92160, 1, 1);
        send_station(0, 0, 0, 131071, -1, 1);
        send_station(COORD_HI, COORD_HI, COORD_HI, 23040, 23040, 65535);
        send_station(COORD_HI, COORD_HI, COORD_HI, 0, 0, 65535);
        send_station(COORD_LO, COORD_LO, COORD_LO, 69120, -23040, 65535);
        send_station(COORD_LO, COORD_LO, COORD_LO, 46080, 0, 65535);
        send_station(COORD_HI, COORD_LO, COORD_HI, 57600, -11520, 40000);
        send_station(COORD_HI, COORD_LO, 0, 11520, 11520, 0);
        send_station(-1, -1, -1, 1, 1, 1);
        send_station(0, 0, 0, 23039, 23039, 65535);
        send_station(0, 0, 0, 23041, 23041, 65535);
        send_station(0, 0, 0, 46079, -23041, 500);
        send_station(0, 0, 0, 69119, -11520, 500);
        send_station(0, 0, 0, 76800, 7680, 1000);
        send_station(COORD_HI - 1, COORD_LO + 1, COORD_HI - 1, 1, 0, 1);
        send_station(0, 0, 0, 100000, 30000, 65535);
        directed_sent = sent;
        drain();

        // random phases, each with its own mix of idling on the two sides
        for (int phase = 0; phase < 4; phase++) begin
            in_burst  <= (phase == 1 || phase == 2);
            out_burst <= (phase == 1 || phase == 3);
            repeat (PHASE_BEATS) send_beat(random_station());
            if (phase == 1)
                drain();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("run covered %0d station requests (%0d directed), %0d next stations checked",
                 sent, directed_sent, checked);
        $display("with wrapped bearings, steep dips, saturation, zero intervals, random stalls");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
src/sss_pkg.sv
src/sss_front.sv
src/sss_cordic_cell.sv
src/sss_back.sv
src/survey_station_step.sv
bench/survey_station_checker.sv
bench/tb_survey_station_step.sv
